### rtl/gap_pkg.sv
package gap_pkg;

    localparam int MAX_TRACKS_DEF = 16;
    localparam int SPAN_W         = 5;
    localparam int POS_W          = 4;
    localparam int DATA_W         = 32;
    localparam int ADDR_W         = 3;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_PLACE  = 2'd1,
        OP_FINISH = 2'd2
    } op_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clear;
        logic finish;
        logic set_conflict;
        logic search_init;
        logic search_step;
        logic mark_step;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        op_t  op;
        logic skip;
        logic cols_over;
        logic found;
        logic fail;
        logic mark_last;
    } stat_t;

endpackage

### rtl/grid_auto_placement.sv
// grid auto-placement, first fit on a MAX_TRACKS x MAX_TRACKS occupancy map
//
// input channel (s_valid/s_ready): one transaction per op. start clears the map,
// cursor, tallest-row mark and sticky conflict; place asks for a rectangle with
// fixed or auto row/column and spans; finish resolves the row count.
// result channel (m_valid/m_ready): exactly one transaction per input transaction.
// configuration: APB-style writes, columns_setting at 0x0, rows_setting at 0x4.
//
// latency: start, finish and skipped places go from dispatch straight to the result
// load. a place scans one grid row per cycle from its start row and then marks one
// row per cycle before its result load; the occupancy read port sets this rate.
// one transaction is in work at a time; s_ready returns together with m_valid, as the
// result is loaded into the output register.
// a stalled receiver holds the result in the output register; the next input
// transaction is still taken and worked, and waits only to load its result.
// reset (synchronous, active low) clears the map, the settings and both channels.
module grid_auto_placement #(
    parameter int MAX_TRACKS = gap_pkg::MAX_TRACKS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gap_pkg::ADDR_W-1:0]  paddr,
    input  logic [gap_pkg::DATA_W-1:0]  pwdata,
    output logic [gap_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    // input channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_op,
    input  logic                        s_out_of_flow,
    input  logic [gap_pkg::SPAN_W-1:0]  s_row_request,
    input  logic [gap_pkg::SPAN_W-1:0]  s_column_request,
    input  logic [gap_pkg::SPAN_W-1:0]  s_row_span,
    input  logic [gap_pkg::SPAN_W-1:0]  s_column_span,
    // result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_status,
    output logic                        m_placed,
    output logic [gap_pkg::POS_W-1:0]   m_row,
    output logic [gap_pkg::POS_W-1:0]   m_column,
    output logic [gap_pkg::SPAN_W-1:0]  m_row_count,
    output logic [gap_pkg::SPAN_W-1:0]  m_column_count
);
    import gap_pkg::*;

    // register select is address bit 2 (word address)
    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ROWS    = 1'b1;

    logic [SPAN_W-1:0] columns_setting_reg;
    logic [SPAN_W-1:0] rows_setting_reg;
    cmd_t              cmd;
    stat_t             stat;

    // settings registers, written on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_setting_reg <= '0;
            rows_setting_reg    <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_COLUMNS: columns_setting_reg <= pwdata[SPAN_W-1:0];
                REG_ROWS:    rows_setting_reg    <= pwdata[SPAN_W-1:0];
                default:     ;
            endcase
        end
    end

    // readback
    always_comb begin
        unique case (paddr[2])
            REG_COLUMNS: prdata = DATA_W'(columns_setting_reg);
            REG_ROWS:    prdata = DATA_W'(rows_setting_reg);
            default:     prdata = '0;
        endcase
    end

    // no wait states
    assign pready = 1'b1;

    // sequencer: accept, dispatch, row scan, row mark, result load
    gap_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // occupancy map, cursor, search counters and output register
    gap_datapath #(
        .MAX_TRACKS (MAX_TRACKS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .s_op             (s_op),
        .s_out_of_flow    (s_out_of_flow),
        .s_row_request    (s_row_request),
        .s_column_request (s_column_request),
        .s_row_span       (s_row_span),
        .s_column_span    (s_column_span),
        .columns_setting  (columns_setting_reg),
        .rows_setting     (rows_setting_reg),
        .m_status         (m_status),
        .m_placed         (m_placed),
        .m_row            (m_row),
        .m_column         (m_column),
        .m_row_count      (m_row_count),
        .m_column_count   (m_column_count)
    );

endmodule

### rtl/gap_ctrl.sv
module gap_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  gap_pkg::stat_t  stat,
    output gap_pkg::cmd_t   cmd
);
    import gap_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EXEC   = 5'b00010,
        ST_SEARCH = 5'b00100,
        ST_MARK   = 5'b01000,
        ST_RESP   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (stat.op)
                    OP_START: begin
                        cmd.clear  = 1'b1;
                        state_next = ST_RESP;
                    end
                    OP_PLACE: begin
                        if (stat.skip) begin
                            state_next = ST_RESP;
                        end else if (stat.cols_over) begin
                            cmd.set_conflict = 1'b1;
                            state_next       = ST_RESP;
                        end else begin
                            cmd.search_init = 1'b1;
                            state_next      = ST_SEARCH;
                        end
                    end
                    OP_FINISH: begin
                        cmd.finish = 1'b1;
                        state_next = ST_RESP;
                    end
                    default: begin
                        state_next = ST_RESP;
                    end
                endcase
            end
            ST_SEARCH: begin
                cmd.search_step = 1'b1;
                if (stat.found) begin
                    state_next = ST_MARK;
                end else if (stat.fail) begin
                    state_next = ST_RESP;
                end
            end
            ST_MARK: begin
                cmd.mark_step = 1'b1;
                if (stat.mark_last) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid_next = cmd.out_load | (m_valid_reg & ~m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

### rtl/gap_datapath.sv
module gap_datapath #(
    parameter int MAX_TRACKS = gap_pkg::MAX_TRACKS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  gap_pkg::cmd_t               cmd,
    output gap_pkg::stat_t              stat,
    input  logic [1:0]                  s_op,
    input  logic                        s_out_of_flow,
    input  logic [gap_pkg::SPAN_W-1:0]  s_row_request,
    input  logic [gap_pkg::SPAN_W-1:0]  s_column_request,
    input  logic [gap_pkg::SPAN_W-1:0]  s_row_span,
    input  logic [gap_pkg::SPAN_W-1:0]  s_column_span,
    input  logic [gap_pkg::SPAN_W-1:0]  columns_setting,
    input  logic [gap_pkg::SPAN_W-1:0]  rows_setting,
    output logic                        m_status,
    output logic                        m_placed,
    output logic [gap_pkg::POS_W-1:0]   m_row,
    output logic [gap_pkg::POS_W-1:0]   m_column,
    output logic [gap_pkg::SPAN_W-1:0]  m_row_count,
    output logic [gap_pkg::SPAN_W-1:0]  m_column_count
);
    import gap_pkg::*;

    localparam int RW = $clog2(MAX_TRACKS);
    localparam int TW = $clog2(MAX_TRACKS + 1);
    localparam int XW = ((TW > SPAN_W) ? TW : SPAN_W) + 2;
    localparam logic [XW-1:0] MAX_X  = XW'(MAX_TRACKS);
    localparam logic [RW-1:0] LAST_R = RW'(MAX_TRACKS - 1);

    // latched item
    logic [1:0]        op_reg;
    logic              oof_reg;
    logic [SPAN_W-1:0] rreq_reg, creq_reg, rspan_reg, cspan_reg;

    // layout state
    logic [MAX_TRACKS-1:0] occ_mem [MAX_TRACKS];
    logic [MAX_TRACKS-1:0] valid_reg;
    logic [MAX_TRACKS-1:0] rd_data_reg;
    logic                  rd_valid_reg;
    logic [TW-1:0]         cursor_row_reg;
    logic [RW-1:0]         cursor_col_reg;
    logic [TW-1:0]         tallest_reg;
    logic                  conflict_reg;

    // search and mark
    logic [RW-1:0]         row_reg;
    logic                  pend_reg;
    logic [SPAN_W-1:0]     cnt_reg [MAX_TRACKS];
    logic [RW-1:0]         mk_row_reg;
    logic [SPAN_W-1:0]     mk_left_reg;
    logic [MAX_TRACKS-1:0] mk_mask_reg;

    // result
    logic              res_placed_reg;
    logic [RW-1:0]     res_row_reg, res_col_reg;
    logic [SPAN_W-1:0] res_rcount_reg;

    // combinational
    logic [MAX_TRACKS-1:0] occ_row;
    logic [XW-1:0]         cols_x, rreq_x, creq_x, rspan_x, cspan_x;
    logic [XW-1:0]         r_start_x, y_x, top_x, cc_x;
    logic [MAX_TRACKS-1:0] span_m, hit, mk_mask_new;
    logic [SPAN_W-1:0]     cnt_new [MAX_TRACKS];
    logic [RW-1:0]         sel_c;
    logic                  found, fail;
    logic                  rd_en;
    logic [RW-1:0]         rd_addr;
    logic [XW-1:0]         implied_x, rows_x;

    assign occ_row   = rd_valid_reg ? rd_data_reg : '0;
    assign cols_x    = (columns_setting == '0) ? XW'(1) : XW'(columns_setting);
    assign rreq_x    = XW'(rreq_reg);
    assign creq_x    = XW'(creq_reg);
    assign rspan_x   = XW'(rspan_reg);
    assign cspan_x   = XW'(cspan_reg);
    assign r_start_x = (rreq_reg != '0) ? (rreq_x - XW'(1)) : XW'(cursor_row_reg);
    assign y_x       = XW'(row_reg);
    assign top_x     = y_x + XW'(1) - rspan_x;

    // per-column run counts of free rows, one grid row per cycle
    always_comb begin
        logic [SPAN_W-1:0] cnt_sat;
        logic              rowfree, colok, posok;
        for (int i = 0; i < MAX_TRACKS; i++) begin
            span_m[i] = (XW'(i) < cspan_x);
        end
        for (int c = 0; c < MAX_TRACKS; c++) begin
            rowfree    = ~|(occ_row & (span_m << c));
            cnt_sat    = (cnt_reg[c] == '1) ? cnt_reg[c] : (cnt_reg[c] + SPAN_W'(1));
            cnt_new[c] = rowfree ? cnt_sat : '0;
            colok      = (XW'(c) + cspan_x) <= cols_x;
            if (creq_reg != '0) begin
                posok = (XW'(c) + XW'(1)) == creq_x;
            end else begin
                posok = (top_x != XW'(cursor_row_reg)) || (XW'(c) >= XW'(cursor_col_reg));
            end
            hit[c] = pend_reg && (XW'(cnt_new[c]) >= rspan_x) && colok && posok;
        end
    end

    // leftmost fitting column
    always_comb begin
        sel_c = '0;
        for (int c = MAX_TRACKS - 1; c >= 0; c--) begin
            if (hit[c]) begin
                sel_c = RW'(c);
            end
        end
    end

    assign found = |hit;
    assign fail  = !found && (!pend_reg || (row_reg == LAST_R) ||
                   ((rreq_reg != '0) && ((y_x + XW'(2)) >= (rreq_x + rspan_x))));
    assign cc_x  = XW'(sel_c) + cspan_x;

    always_comb begin
        for (int i = 0; i < MAX_TRACKS; i++) begin
            mk_mask_new[i] = (XW'(i) >= XW'(sel_c)) && (XW'(i) < cc_x);
        end
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = row_reg + RW'(1);
        if (cmd.search_init) begin
            rd_en   = r_start_x < MAX_X;
            rd_addr = r_start_x[RW-1:0];
        end else if (cmd.search_step) begin
            if (found) begin
                rd_en   = 1'b1;
                rd_addr = top_x[RW-1:0];
            end else if (!fail) begin
                rd_en   = 1'b1;
                rd_addr = row_reg + RW'(1);
            end
        end else if (cmd.mark_step && (mk_left_reg != SPAN_W'(1))) begin
            rd_en   = 1'b1;
            rd_addr = mk_row_reg + RW'(1);
        end
    end

    assign implied_x = (tallest_reg == '0) ? XW'(1) : XW'(tallest_reg);
    assign rows_x    = (rows_setting != '0) ? XW'(rows_setting) : implied_x;

    // occupancy rows, read data registered
    always_ff @(posedge aclk) begin
        if (cmd.mark_step) begin
            occ_mem[mk_row_reg] <= occ_row | mk_mask_reg;
        end
        if (rd_en) begin
            rd_data_reg <= occ_mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            rd_valid_reg   <= 1'b0;
            cursor_row_reg <= '0;
            cursor_col_reg <= '0;
            tallest_reg    <= '0;
            conflict_reg   <= 1'b0;
        end else begin
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
            if (cmd.clear) begin
                valid_reg      <= '0;
                cursor_row_reg <= '0;
                cursor_col_reg <= '0;
                tallest_reg    <= '0;
                conflict_reg   <= 1'b0;
            end
            if (cmd.mark_step) begin
                valid_reg[mk_row_reg] <= 1'b1;
            end
            if (cmd.set_conflict) begin
                conflict_reg <= 1'b1;
            end
            if (cmd.finish && ((rows_x > MAX_X) || (rows_x < XW'(tallest_reg)))) begin
                conflict_reg <= 1'b1;
            end
            if (cmd.search_step) begin
                if (found) begin
                    if ((y_x + XW'(1)) > XW'(tallest_reg)) begin
                        tallest_reg <= TW'(y_x + XW'(1));
                    end
                    if (cc_x >= cols_x) begin
                        cursor_col_reg <= '0;
                        cursor_row_reg <= TW'(top_x + XW'(1));
                    end else begin
                        cursor_col_reg <= cc_x[RW-1:0];
                        cursor_row_reg <= TW'(top_x);
                    end
                end else if (fail) begin
                    conflict_reg <= 1'b1;
                end
            end
        end
    end

    // item, search and result registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg         <= s_op;
            oof_reg        <= s_out_of_flow;
            rreq_reg       <= s_row_request;
            creq_reg       <= s_column_request;
            rspan_reg      <= (s_row_span == '0) ? SPAN_W'(1) : s_row_span;
            cspan_reg      <= (s_column_span == '0) ? SPAN_W'(1) : s_column_span;
            res_placed_reg <= 1'b0;
            res_row_reg    <= '0;
            res_col_reg    <= '0;
            res_rcount_reg <= '0;
        end
        if (cmd.finish && !(rows_x > MAX_X) && !(rows_x < XW'(tallest_reg)) &&
            !conflict_reg) begin
            res_rcount_reg <= rows_x[SPAN_W-1:0];
        end
        if (cmd.search_init) begin
            row_reg  <= r_start_x[RW-1:0];
            pend_reg <= r_start_x < MAX_X;
            for (int c = 0; c < MAX_TRACKS; c++) begin
                cnt_reg[c] <= '0;
            end
        end
        if (cmd.search_step) begin
            if (found) begin
                res_placed_reg <= 1'b1;
                res_row_reg    <= top_x[RW-1:0];
                res_col_reg    <= sel_c;
                mk_row_reg     <= top_x[RW-1:0];
                mk_left_reg    <= rspan_reg;
                mk_mask_reg    <= mk_mask_new;
            end else if (!fail) begin
                row_reg <= row_reg + RW'(1);
                for (int c = 0; c < MAX_TRACKS; c++) begin
                    cnt_reg[c] <= cnt_new[c];
                end
            end
        end
        if (cmd.mark_step) begin
            mk_row_reg  <= mk_row_reg + RW'(1);
            mk_left_reg <= mk_left_reg - SPAN_W'(1);
        end
        if (cmd.out_load) begin
            m_status       <= conflict_reg;
            m_placed       <= res_placed_reg;
            m_row          <= POS_W'(res_row_reg);
            m_column       <= POS_W'(res_col_reg);
            m_row_count    <= res_rcount_reg;
            m_column_count <= cols_x[SPAN_W-1:0];
        end
    end

    assign stat.op        = op_t'(op_reg);
    assign stat.skip      = oof_reg || conflict_reg;
    assign stat.cols_over = cols_x > MAX_X;
    assign stat.found     = found;
    assign stat.fail      = fail;
    assign stat.mark_last = (mk_left_reg == SPAN_W'(1));

    // the area found by the search must be free when it is marked
    a_mark_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mark_step |-> ((occ_row & mk_mask_reg) == '0))
        else $error("marking an occupied cell");

    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |=> (!conflict_reg && (valid_reg == '0) && (tallest_reg == '0)))
        else $error("layout not cleared on start");

    a_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.search_step && found) |=> (XW'(cursor_col_reg) < cols_x))
        else $error("cursor column past column count");

    a_tallest: assert property (@(posedge aclk) disable iff (!aresetn)
        XW'(tallest_reg) <= MAX_X)
        else $error("tallest row beyond grid");

endmodule
